// ===== design/q2e_pkg.sv =====
// q2e_pkg: constants and types for the quaternion to Euler angle pipeline.
// No dependencies.
`timescale 1ns / 1ps
package q2e_pkg;
   localparam int ATAN_W = 34;   // Q.30 angle accumulator, covers +-pi with margin
   localparam logic signed [ATAN_W-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [ATAN_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

   localparam int CSR_DIRECTION_MODE = 0;
   localparam int CSR_LOCK_THRESHOLD = 1;

   function automatic logic signed [ATAN_W-1:0] atan_entry(input int idx);
      logic [31:0] v;
      begin
         case (idx)
            0: v = 32'd843314857;   1: v = 32'd497837829;
            2: v = 32'd263043837;   3: v = 32'd133525159;
            4: v = 32'd67021687;    5: v = 32'd33543516;
            6: v = 32'd16775851;    7: v = 32'd8388437;
            8: v = 32'd4194283;     9: v = 32'd2097149;
            10: v = 32'd1048576;    11: v = 32'd524288;
            12: v = 32'd262144;     13: v = 32'd131072;
            14: v = 32'd65536;      15: v = 32'd32768;
            16: v = 32'd16384;      17: v = 32'd8192;
            18: v = 32'd4096;       19: v = 32'd2048;
            20: v = 32'd1024;       21: v = 32'd512;
            22: v = 32'd256;        23: v = 32'd128;
            24: v = 32'd64;         25: v = 32'd32;
            26: v = 32'd16;         27: v = 32'd8;
            28: v = 32'd4;          29: v = 32'd2;
            30: v = 32'd1;          default: v = 32'd0;
         endcase
         atan_entry = signed'({2'b00, v});
      end
   endfunction
endpackage

// ===== design/q2e_cordic.sv =====
// q2e_cordic: pipelined vectoring CORDIC atan2, one rotation per stage.
// Depends on q2e_pkg. Input magnitudes must be below 2^(VW-2).
`timescale 1ns / 1ps
module q2e_cordic #(
   parameter int VW    = 44,
   parameter int STEPS = 16
) (
   input  logic                            clock,
   input  logic                            advance,
   input  logic signed [VW-1:0]            vec_y,
   input  logic signed [VW-1:0]            vec_x,
   output logic signed [q2e_pkg::ATAN_W-1:0] angle
);
   import q2e_pkg::*;

   logic signed [VW-1:0]     x_ff [0:STEPS];
   logic signed [VW-1:0]     y_ff [0:STEPS];
   logic signed [ATAN_W-1:0] z_ff [0:STEPS];
   logic                     zero_ff [0:STEPS];
   logic signed [VW-1:0]     x0_in, y0_in;
   logic signed [ATAN_W-1:0] z0_in;

   // Quadrant pre-rotation for negative x.
   always_comb begin
      x0_in = vec_x;
      y0_in = vec_y;
      z0_in = '0;
      if (vec_x < 0) begin
         if (vec_y >= 0) begin
            x0_in = vec_y;
            y0_in = -vec_x;
            z0_in = HALF_PI_Q30;
         end else begin
            x0_in = -vec_y;
            y0_in = vec_x;
            z0_in = -HALF_PI_Q30;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         zero_ff[0] <= (vec_x == 0) && (vec_y == 0);
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (advance) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_entry(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_entry(i);
            end
         end
      end
   end

   always_comb begin
      if (zero_ff[STEPS])         angle = '0;
      else if (z_ff[STEPS] > PI_Q30)  angle = PI_Q30;
      else if (z_ff[STEPS] < -PI_Q30) angle = -PI_Q30;
      else                         angle = z_ff[STEPS];
   end
endmodule

// ===== design/q2e_isqrt.sv =====
// q2e_isqrt: pipelined restoring integer square root, one result bit per stage.
// No package dependency.
`timescale 1ns / 1ps
module q2e_isqrt #(
   parameter int IN_W = 30
) (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [IN_W-1:0]      radicand,
   output logic [(IN_W+1)/2-1:0] root
);
   localparam int RW = (IN_W + 1) / 2;
   localparam int PW = 2 * RW;

   logic [PW-1:0] rem_ff [0:RW];
   logic [PW-1:0] res_ff [0:RW];

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= PW'(radicand);
         res_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < RW; i++) begin : g_bit
      localparam logic [PW-1:0] BIT = PW'(1) << (2 * (RW - 1 - i));
      always_ff @(posedge clock) begin
         if (advance) begin
            if (rem_ff[i] >= res_ff[i] + BIT) begin
               rem_ff[i+1] <= rem_ff[i] - (res_ff[i] + BIT);
               res_ff[i+1] <= (res_ff[i] >> 1) + BIT;
            end else begin
               rem_ff[i+1] <= rem_ff[i];
               res_ff[i+1] <= res_ff[i] >> 1;
            end
         end
      end
   end

   assign root = res_ff[RW][RW-1:0];
endmodule

// ===== design/quaternion_to_euler.sv =====
// quaternion_to_euler: unit quaternion to heading / pitch / bank, pipelined.
// Stages in order: products, sums, square root, CORDIC, output; one transfer per cycle
// while rsp_stall does not hold the pipeline.
// The whole pipeline advances together; rsp_stall freezes every stage, and
// req_stall is raised only when the output register is full and stalled.
// Reset (synchronous) clears valid bits and loads register reset values.
// Depends on q2e_pkg, q2e_cordic, q2e_isqrt.
`timescale 1ns / 1ps
module quaternion_to_euler #(
   parameter int QUAT_FRAC_BITS  = 14,
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int CORDIC_STEPS    = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [0:0]         csr_index,
   input  logic [14:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_heading_angle,
   output logic signed [14:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_bank_angle,
   output logic               rsp_gimbal_locked
);
   import q2e_pkg::*;

   localparam int F      = QUAT_FRAC_BITS;
   localparam int PW     = 36;  // products and atan2 arguments, Q.2F
   localparam int MW     = 33;  // multiplier width: 17-bit signed w by 16-bit component
   localparam int VW     = PW + 2;
   localparam int SQ_IN  = 2 * F + 2;
   localparam int SQ_OUT = (SQ_IN + 1) / 2;
   localparam int SQ_LAT = SQ_OUT + 1;
   localparam int CO_LAT = CORDIC_STEPS + 1;
   localparam int SH     = 30 - ANGLE_FRAC_BITS;
   localparam int SQW    = 2 * F + 4;
   // total stages: S1 products, S2 sums, sqrt, CORDIC, output
   localparam int LAT    = 2 + SQ_LAT + CO_LAT + 1;

   logic       mode_ff;
   logic [14:0] thr_ff;
   logic       advance;
   logic [LAT-1:0] vld_ff;

   // Stall whole pipe only when the output stage holds an untaken result.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         thr_ff  <= 15'd16382;
      end else if (csr_write) begin
         case (csr_index)
            1'(CSR_DIRECTION_MODE): mode_ff <= csr_data[0];
            1'(CSR_LOCK_THRESHOLD): thr_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[LAT-2:0], req_valid};
   end

   // Stage 1: the nine products (w sign folded in by mode).
   // ws is one bit wider so that negating the most negative w cannot wrap.
   logic signed [PW-1:0] pyz_ff, pwx_ff, pxz_ff, pwy_ff, pxy_ff, pwz_ff;
   logic signed [PW-1:0] pxx_ff, pyy_ff, pzz_ff;
   logic signed [16:0]   ws;
   assign ws = mode_ff ? -17'(req_quat_w) : 17'(req_quat_w);

   always_ff @(posedge clock) begin
      if (advance) begin
         pyz_ff <= PW'(MW'(req_quat_y) * MW'(req_quat_z));
         pwx_ff <= PW'(MW'(ws) * MW'(req_quat_x));
         pxz_ff <= PW'(MW'(req_quat_x) * MW'(req_quat_z));
         pwy_ff <= PW'(MW'(ws) * MW'(req_quat_y));
         pxy_ff <= PW'(MW'(req_quat_x) * MW'(req_quat_y));
         pwz_ff <= PW'(MW'(ws) * MW'(req_quat_z));
         pxx_ff <= PW'(MW'(req_quat_x) * MW'(req_quat_x));
         pyy_ff <= PW'(MW'(req_quat_y) * MW'(req_quat_y));
         pzz_ff <= PW'(MW'(req_quat_z) * MW'(req_quat_z));
      end
   end

   // Stage 2: pitch sine, lock decision, atan2 arguments.
   localparam logic signed [PW-1:0] HALF = PW'(1) <<< (2 * F - 1);
   localparam logic signed [PW-1:0] ONE  = PW'(1) <<< F;
   logic signed [PW-1:0] sp_raw, sp_sat, sp_mag;
   logic                 lock_in;
   logic signed [PW-1:0] hy_in, hx_in;

   always_comb begin
      sp_raw = ((pwx_ff - pyz_ff) <<< 1) + (PW'(1) <<< (F - 1));
      sp_raw = sp_raw >>> F;
      if (sp_raw > ONE)       sp_sat = ONE;
      else if (sp_raw < -ONE) sp_sat = -ONE;
      else                    sp_sat = sp_raw;
      sp_mag  = (sp_sat < 0) ? -sp_sat : sp_sat;
      lock_in = sp_mag > PW'(thr_ff);
      if (lock_in) begin
         hy_in = pwy_ff - pxz_ff;
         hx_in = HALF - pyy_ff - pzz_ff;
      end else begin
         hy_in = pxz_ff + pwy_ff;
         hx_in = HALF - pxx_ff - pyy_ff;
      end
   end

   logic signed [F+1:0]  sp_ff;
   logic                 lock_ff;
   logic signed [PW-1:0] hy_ff, hx_ff, by_ff, bx_ff;
   logic [SQ_IN-1:0]     rad_in;
   logic signed [F+1:0]  sp_nar;
   logic signed [SQW-1:0] sp_sq;
   // saturated sine fits F+2 bits, so the square stays narrow
   assign sp_nar = sp_sat[F+1:0];
   assign sp_sq  = SQW'(sp_nar) * SQW'(sp_nar);
   assign rad_in = SQ_IN'(SQW'(ONE * ONE) - sp_sq);

   always_ff @(posedge clock) begin
      if (advance) begin
         sp_ff   <= sp_sat[F+1:0];
         lock_ff <= lock_in;
         hy_ff   <= hy_in;
         hx_ff   <= hx_in;
         by_ff   <= pxy_ff + pwz_ff;
         bx_ff   <= HALF - pxx_ff - pzz_ff;
      end
   end

   // Square root of 1 - sp^2 for asin; side data delayed alongside.
   logic [SQ_OUT-1:0] cos_root;
   q2e_isqrt #(.IN_W(SQ_IN)) u_sqrt (
      .clock(clock), .advance(advance), .radicand(rad_in), .root(cos_root)
   );

   logic signed [F+1:0]  sp_d  [0:SQ_LAT-1];
   logic                 lk_d  [0:SQ_LAT-1];
   logic signed [PW-1:0] hy_d  [0:SQ_LAT-1];
   logic signed [PW-1:0] hx_d  [0:SQ_LAT-1];
   logic signed [PW-1:0] by_d  [0:SQ_LAT-1];
   logic signed [PW-1:0] bx_d  [0:SQ_LAT-1];

   always_ff @(posedge clock) begin
      if (advance) begin
         sp_d[0] <= sp_ff;  lk_d[0] <= lock_ff;
         hy_d[0] <= hy_ff;  hx_d[0] <= hx_ff;
         by_d[0] <= by_ff;  bx_d[0] <= bx_ff;
         for (int k = 1; k < SQ_LAT; k++) begin
            sp_d[k] <= sp_d[k-1];  lk_d[k] <= lk_d[k-1];
            hy_d[k] <= hy_d[k-1];  hx_d[k] <= hx_d[k-1];
            by_d[k] <= by_d[k-1];  bx_d[k] <= bx_d[k-1];
         end
      end
   end
   // sqrt input was rad_in registered with sp_ff, so root aligns with sp_d[SQ_LAT-2];
   // realign by one more register on the sqrt side.
   logic [SQ_OUT-1:0] cos_ff;
   always_ff @(posedge clock) begin
      if (advance) cos_ff <= cos_root;
   end

   // Three CORDICs in parallel.
   logic signed [ATAN_W-1:0] p_ang, h_ang, b_ang;
   q2e_cordic #(.VW(VW), .STEPS(CORDIC_STEPS)) u_pitch (
      .clock(clock), .advance(advance),
      .vec_y(VW'(sp_d[SQ_LAT-1])), .vec_x(VW'({1'b0, cos_ff})), .angle(p_ang)
   );
   q2e_cordic #(.VW(VW), .STEPS(CORDIC_STEPS)) u_head (
      .clock(clock), .advance(advance),
      .vec_y(VW'(hy_d[SQ_LAT-1])), .vec_x(VW'(hx_d[SQ_LAT-1])), .angle(h_ang)
   );
   q2e_cordic #(.VW(VW), .STEPS(CORDIC_STEPS)) u_bank (
      .clock(clock), .advance(advance),
      .vec_y(VW'(by_d[SQ_LAT-1])), .vec_x(VW'(bx_d[SQ_LAT-1])), .angle(b_ang)
   );

   logic signed [F+1:0] sp_c [0:CO_LAT-1];
   logic                lk_c [0:CO_LAT-1];
   always_ff @(posedge clock) begin
      if (advance) begin
         sp_c[0] <= sp_d[SQ_LAT-1];
         lk_c[0] <= lk_d[SQ_LAT-1];
         for (int k = 1; k < CO_LAT; k++) begin
            sp_c[k] <= sp_c[k-1];
            lk_c[k] <= lk_c[k-1];
         end
      end
   end

   // Output stage: clamp, round to Q.ANGLE_FRAC_BITS, select lock branch.
   function automatic logic signed [ATAN_W-1:0] to_ang(input logic signed [ATAN_W-1:0] a);
      to_ang = (a + (ATAN_W'(1) <<< (SH - 1))) >>> SH;
   endfunction

   logic signed [ATAN_W-1:0] p_cl, p_out, h_out, b_out;
   logic                     lk_o;
   always_comb begin
      lk_o = lk_c[CO_LAT-1];
      if (p_ang > HALF_PI_Q30)       p_cl = HALF_PI_Q30;
      else if (p_ang < -HALF_PI_Q30) p_cl = -HALF_PI_Q30;
      else                           p_cl = p_ang;
      if (lk_o) p_out = to_ang((sp_c[CO_LAT-1] > 0) ? HALF_PI_Q30 : -HALF_PI_Q30);
      else      p_out = to_ang(p_cl);
      h_out = to_ang(h_ang);
      b_out = lk_o ? '0 : to_ang(b_ang);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_heading_angle <= h_out[15:0];
         rsp_pitch_angle   <= p_out[14:0];
         rsp_bank_angle    <= b_out[15:0];
         rsp_gimbal_locked <= lk_o;
      end
   end

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pitch_angle))
      else $error("result changed under stall");
   // No bank angle under lock.
   a_bank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gimbal_locked |-> rsp_bank_angle == 0)
      else $error("bank nonzero under lock");
   // Input is taken whenever the output is free.
   a_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("stall without pending result");
endmodule

// ===== sim/quaternion_to_euler_tb.sv =====
// quaternion_to_euler_tb: self-checking bench for the quaternion to Euler angle pipeline.
// Predicts each transfer in fixed point and compares results in order; needs q2e_pkg and the RTL.
`timescale 1ns / 1ps
module quaternion_to_euler_tb;
   import q2e_pkg::*;

   typedef struct packed {
      logic signed [15:0] w, x, y, z;
   } quat_type;

   typedef struct packed {
      logic signed [15:0] heading;
      logic signed [14:0] pitch;
      logic signed [15:0] bank;
      logic               locked;
   } euler_type;

   localparam longint ANG_PI      = 64'd3373259426;
   localparam longint ANG_HALF_PI = 64'd1686629713;
   localparam longint VEC_LIMIT   = 64'sd1 << 40;
   localparam int     DRAIN_WAIT  = 100;        // comfortably past the pipeline depth
   localparam int     CYCLE_LIMIT = 300000;

   localparam longint ATAN_Q30 [0:15] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write = 1'b0;
   logic [0:0]         csr_index = '0;
   logic [14:0]        csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_heading_angle;
   logic signed [14:0] rsp_pitch_angle;
   logic signed [15:0] rsp_bank_angle;
   logic               rsp_gimbal_locked;

   quaternion_to_euler i_dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_quat_w(req_quat_w), .req_quat_x(req_quat_x),
      .req_quat_y(req_quat_y), .req_quat_z(req_quat_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_heading_angle(rsp_heading_angle), .rsp_pitch_angle(rsp_pitch_angle),
      .rsp_bank_angle(rsp_bank_angle), .rsp_gimbal_locked(rsp_gimbal_locked)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // bench copy of the registers, updated with every CSR write
   logic        mode_inv = 1'b0;
   logic [14:0] lock_thr = 15'd16382;

   quat_type  pending_quats[$];
   euler_type angle_queue[$];
   int     mismatches = 0;
   int     cycles = 0;
   bit     calm = 1'b0;     // no idling on either side in the closing phase
   bit     req_taken = 1'b0;

   // vectoring CORDIC in Q.30 with argument pre-scaling and quadrant fold
   function automatic longint cordic_atan2(longint ya, longint xa);
      longint ang, t, dx, dy;
      ang = 0;
      if (xa == 0 && ya == 0) return 0;
      while ((xa < 0 ? -xa : xa) >= VEC_LIMIT || (ya < 0 ? -ya : ya) >= VEC_LIMIT) begin
         xa = xa >>> 1;
         ya = ya >>> 1;
      end
      if (xa < 0) begin
         t = xa;
         if (ya >= 0) begin
            xa = ya; ya = -t; ang = ANG_HALF_PI;
         end else begin
            xa = -ya; ya = t; ang = -ANG_HALF_PI;
         end
      end
      for (int i = 0; i < 16; i++) begin
         dx = ya >>> i;
         dy = xa >>> i;
         if (ya >= 0) begin
            xa += dx; ya -= dy; ang += ATAN_Q30[i];
         end else begin
            xa -= dx; ya += dy; ang -= ATAN_Q30[i];
         end
      end
      if (ang > ANG_PI) ang = ANG_PI;
      if (ang < -ANG_PI) ang = -ANG_PI;
      return ang;
   endfunction

   function automatic longint root_floor(longint v);
      longint res, b;
      res = 0;
      b = 64'sd1 << 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >>> 1) + b;
         end else begin
            res = res >>> 1;
         end
         b = b >>> 2;
      end
      return res;
   endfunction

   // Q.30 radians down to Q2.13 with rounding
   function automatic longint q30_to_q13(longint a);
      return (a + (64'sd1 << 16)) >>> 17;
   endfunction

   function automatic euler_type euler_from_quat(quat_type q);
      longint w, x, y, z, s, sp, p, c;
      longint half;
      euler_type r;
      w = q.w; x = q.x; y = q.y; z = q.z;
      s = mode_inv ? -1 : 1;
      half = 64'sd1 << 27;
      sp = -2 * (y * z - s * w * x);
      sp = (sp + 8192) >>> 14;
      if (sp > 16384) sp = 16384;
      if (sp < -16384) sp = -16384;
      if ((sp < 0 ? -sp : sp) > longint'(lock_thr)) begin
         // gimbal lock: pitch pinned, bank zero, alternate heading
         r.locked  = 1'b1;
         r.pitch   = 15'(q30_to_q13(sp > 0 ? ANG_HALF_PI : -ANG_HALF_PI));
         r.heading = 16'(q30_to_q13(cordic_atan2(-x * z + s * w * y, half - y * y - z * z)));
         r.bank    = '0;
      end else begin
         c = root_floor(16384 * 16384 - sp * sp);
         p = cordic_atan2(sp, c);
         if (p > ANG_HALF_PI) p = ANG_HALF_PI;
         if (p < -ANG_HALF_PI) p = -ANG_HALF_PI;
         r.locked  = 1'b0;
         r.pitch   = 15'(q30_to_q13(p));
         r.heading = 16'(q30_to_q13(cordic_atan2(x * z + s * w * y, half - x * x - y * y)));
         r.bank    = 16'(q30_to_q13(cordic_atan2(x * y + s * w * z, half - x * x - z * z)));
      end
      return r;
   endfunction

   // request driver: holds a stalled transfer, else idles in bursts or sends the next item
   int req_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // payload held
         end else if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_quats.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            req_gap <= $urandom_range(0, 6);
            req_valid <= 1'b0;
         end else begin
            quat_type q;
            q = pending_quats.pop_front();
            req_quat_w <= q.w; req_quat_x <= q.x;
            req_quat_y <= q.y; req_quat_z <= q.z;
            req_valid <= 1'b1;
         end
      end
   end

   // result side back-pressure in bursts of random length
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_stall <= 1'b1;
      end else if (!calm && !reset && $urandom_range(0, 5) == 0) begin
         rsp_gap <= $urandom_range(0, 6);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: predict on each accepted request, check each accepted result
   always @(posedge clock) begin
      cycles <= cycles + 1;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            quat_type q;
            q = '{req_quat_w, req_quat_x, req_quat_y, req_quat_z};
            angle_queue.push_back(euler_from_quat(q));
            req_taken = 1'b1;
         end
         if (csr_write) begin
            if (csr_index == 1'(CSR_DIRECTION_MODE)) mode_inv = csr_data[0];
            else lock_thr = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            euler_type got, exp_r;
            got = '{rsp_heading_angle, rsp_pitch_angle, rsp_bank_angle, rsp_gimbal_locked};
            if (angle_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result transfer: h=%0d p=%0d b=%0d l=%0d",
                           got.heading, got.pitch, got.bank, got.locked);
            end else begin
               exp_r = angle_queue.pop_front();
               if (got !== exp_r) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp h=%0d p=%0d b=%0d l=%0d, got h=%0d p=%0d b=%0d l=%0d",
                              exp_r.heading, exp_r.pitch, exp_r.bank, exp_r.locked,
                              got.heading, got.pitch, got.bank, got.locked);
               end
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic csr_put(input int idx, input int value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= 1'(idx);
      csr_data  <= 15'(value);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_quats.size() != 0 || req_valid || angle_queue.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   function automatic quat_type make_quat(int w, int x, int y, int z);
      quat_type q;
      q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
      return q;
   endfunction

   // random quaternion: mostly unit length, some near gimbal lock, some raw
   function automatic quat_type random_quat();
      real c[4], n;
      int  kind, a;
      kind = $urandom_range(0, 9);
      if (kind == 0)
         return make_quat($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                          $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
      if (kind <= 2) begin
         // w and x (or y and z) nearly equal in size, the rest small
         a = 11585 + int'($urandom_range(0, 60)) - 30;
         c[0] = a;
         c[1] = ($urandom_range(0, 1) ? a : -a) + int'($urandom_range(0, 40)) - 20;
         c[2] = $urandom_range(0, 400) - 200.0;
         c[3] = $urandom_range(0, 400) - 200.0;
         if ($urandom_range(0, 1))
            return make_quat($rtoi(c[2]), $rtoi(c[3]), $rtoi(c[0]), $rtoi(c[1]));
         return make_quat($rtoi(c[0]), $rtoi(c[1]), $rtoi(c[2]), $rtoi(c[3]));
      end
      do begin
         n = 0.0;
         for (int i = 0; i < 4; i++) begin
            c[i] = $urandom_range(0, 32768) - 16384.0;
            n += c[i] * c[i];
         end
      end while (n < 1.0);
      n = $sqrt(n);
      for (int i = 0; i < 4; i++) c[i] = c[i] * 16384.0 / n;
      return make_quat($rtoi(c[0]), $rtoi(c[1]), $rtoi(c[2]), $rtoi(c[3]));
   endfunction

   initial begin
      int modes[6]      = '{0, 1, 0, 1, 1, 0};
      int thresholds[6] = '{16382, 16382, 0, 16384, 16000, 16382};
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: identity, extremes, lock both ways, degenerate inputs
      pending_quats.push_back(make_quat(16384, 0, 0, 0));
      pending_quats.push_back(make_quat(0, 0, 0, 0));
      pending_quats.push_back(make_quat(-16384, 0, 0, 0));
      pending_quats.push_back(make_quat(0, 16384, 0, 0));
      pending_quats.push_back(make_quat(0, 0, 16384, 0));
      pending_quats.push_back(make_quat(0, 0, 0, 16384));
      pending_quats.push_back(make_quat(0, -16384, 0, 0));
      pending_quats.push_back(make_quat(0, 0, -16384, 0));
      pending_quats.push_back(make_quat(0, 0, 0, -16384));
      pending_quats.push_back(make_quat(11585, 11585, 0, 0));    // pitch +90, locked
      pending_quats.push_back(make_quat(11585, -11585, 0, 0));   // pitch -90, locked
      pending_quats.push_back(make_quat(0, 0, 11585, 11585));
      pending_quats.push_back(make_quat(11584, 11584, 5, 5));    // just under lock
      pending_quats.push_back(make_quat(16384, 16384, 16384, 16384));
      pending_quats.push_back(make_quat(-16384, -16384, -16384, -16384));
      pending_quats.push_back(make_quat(16384, -16384, 16384, -16384));
      pending_quats.push_back(make_quat(-16384, 16384, 16384, -16384)); // sp cancels to zero
      pending_quats.push_back(make_quat(8192, 8192, 8192, 8192));
      pending_quats.push_back(make_quat(8192, -8192, 8192, -8192));
      pending_quats.push_back(make_quat(-1, -1, -1, -1));
      pending_quats.push_back(make_quat(1, 0, 0, 0));

      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 5) calm = 1'b1;
         // directed items and the first phase run with the reset values
         if (ph > 0) begin
            csr_put(CSR_DIRECTION_MODE, modes[ph]);
            csr_put(CSR_LOCK_THRESHOLD, ph == 4 ? $urandom_range(0, 32767) : thresholds[ph]);
         end
         for (int i = 0; i < 150; i++) pending_quats.push_back(random_quat());
         wait_drained();
      end

      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
design/q2e_pkg.sv
design/q2e_cordic.sv
design/q2e_isqrt.sv
design/quaternion_to_euler.sv
sim/quaternion_to_euler_tb.sv
